FILE: hw/rtl/cdc_pkg.sv
// Shared types and constants of the capability derivation checker.
package cdc_pkg;

    localparam int KIND_W   = 3;
    localparam int LOW_W    = 40;
    localparam int WORD_W   = 32;
    localparam int RIGHTS_W = 8;
    localparam int NAPOT_W  = 44;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W    = 4;

    localparam logic [KIND_W-1:0] KIND_TIME = 3'd1;
    localparam logic [KIND_W-1:0] KIND_MEM  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_PMP  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_MON  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_CHAN = 3'd5;
    localparam logic [KIND_W-1:0] KIND_SOCK = 3'd6;

    localparam logic [CFG_IDX_W-1:0] CFG_SOCKET_PERM = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOCKET_MODE = 1'd1;

    localparam logic [CFG_W-1:0] SOCKET_PERM_RESET = 4'd15;
    localparam logic [CFG_W-1:0] SOCKET_MODE_RESET = 4'd3;

    typedef struct packed {
        logic [KIND_W-1:0]   parent_kind;
        logic [LOW_W-1:0]    parent_low;
        logic [WORD_W-1:0]   parent_mark;
        logic [WORD_W-1:0]   parent_high;
        logic [WORD_W-1:0]   parent_key;
        logic [RIGHTS_W-1:0] parent_rights;
        logic [KIND_W-1:0]   child_kind;
        logic [LOW_W-1:0]    child_low;
        logic [WORD_W-1:0]   child_mark;
        logic [WORD_W-1:0]   child_high;
        logic [WORD_W-1:0]   child_key;
        logic [RIGHTS_W-1:0] child_rights;
    } cdc_pair_t;

    typedef struct packed {
        logic may_derive;
        logic may_revoke;
        logic child_valid;
    } cdc_verdict_t;

    typedef struct packed {
        logic [KIND_W-1:0] pkind;
        logic [KIND_W-1:0] ckind;
        logic key_eq;
        logic low_eq;
        logic rwx_sub;
        logic rights_eq;
        logic pkey_zero;
        logic ckey_zero;
        logic high_le;
        logic mark_in;
        logic low_in;
        logic mark_sock_in;
        logic low_sock_in;
        logic pmp_derive_in;
        logic pmp_revoke_in;
        logic range_ok;
        logic pmp_ok;
        logic sock_ok;
    } cdc_flags_t;

endpackage

FILE: hw/rtl/cdc_verdict.sv
// Kind selection that turns the compare flags into the three result flags.
module cdc_verdict
    import cdc_pkg::*;
(
    input  cdc_flags_t   flags,
    output cdc_verdict_t verdict
);

    always_comb
    begin
        verdict.may_derive = 1'b0;
        verdict.may_revoke = 1'b0;
        unique case (flags.pkind)
            KIND_TIME:
            begin
                verdict.may_derive = (flags.ckind == KIND_TIME) && flags.key_eq &&
                                     flags.low_eq && flags.high_le;
                verdict.may_revoke = (flags.ckind == KIND_TIME) && flags.key_eq &&
                                     flags.low_in;
            end
            KIND_MEM:
            begin
                if (flags.ckind == KIND_PMP)
                begin
                    verdict.may_derive = flags.pmp_derive_in && flags.rwx_sub;
                    verdict.may_revoke = flags.pmp_revoke_in;
                end
                else
                begin
                    verdict.may_derive = (flags.ckind == KIND_MEM) && flags.key_eq &&
                                         flags.mark_in && flags.rwx_sub;
                    verdict.may_revoke = (flags.ckind == KIND_MEM) && flags.key_eq &&
                                         flags.low_in;
                end
            end
            KIND_MON:
            begin
                verdict.may_derive = (flags.ckind == KIND_MON) && flags.mark_in;
                verdict.may_revoke = (flags.ckind == KIND_MON) && flags.low_in;
            end
            KIND_CHAN:
            begin
                if (flags.ckind == KIND_SOCK)
                begin
                    verdict.may_derive = flags.ckey_zero && flags.mark_sock_in;
                    verdict.may_revoke = flags.low_sock_in;
                end
                else
                begin
                    verdict.may_derive = (flags.ckind == KIND_CHAN) && flags.mark_in;
                    verdict.may_revoke = (flags.ckind == KIND_CHAN) && flags.low_in;
                end
            end
            KIND_SOCK:
            begin
                verdict.may_derive = (flags.ckind == KIND_SOCK) && flags.low_eq &&
                                     flags.pkey_zero && !flags.ckey_zero &&
                                     flags.rights_eq;
                verdict.may_revoke = flags.pkey_zero && !flags.ckey_zero && flags.low_eq;
            end
            default:
            begin
                verdict.may_derive = 1'b0;
                verdict.may_revoke = 1'b0;
            end
        endcase

        unique case (flags.ckind)
            KIND_TIME, KIND_MEM, KIND_MON, KIND_CHAN: verdict.child_valid = flags.range_ok;
            KIND_PMP:  verdict.child_valid = flags.pmp_ok;
            KIND_SOCK: verdict.child_valid = flags.sock_ok;
            default:   verdict.child_valid = 1'b0;
        endcase
    end

endmodule

FILE: hw/rtl/capability_derivation_checker.sv
// Top level of the capability derivation checker: three-stage pipeline.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-------------------------------
//  pair     | pair_valid / pair_ready    | pair (cdc_pair_t)
//  verdict  | verdict_valid/verdict_ready| verdict (cdc_verdict_t)
//  config   | cfg_we                     | cfg_index, cfg_wdata
//
//  One beat enters per cycle while pair_ready is high; a pair passes the stage 1,
//  stage 2 and output registers before its verdict appears. Stage 1 forms block
//  addresses and the NAPOT region, stage 2 runs the range compares, stage 3 selects by kind into the output register.
//  Reset clears the stage valid bits and loads socket masks 15 and 3.
//  A stalled verdict holds each occupied stage whose next stage is also held; empty stages still fill.
module capability_derivation_checker
    import cdc_pkg::*;
#(
    parameter int MIN_BLOCK_SHIFT = 12,
    parameter int MAX_BLOCK_SHIFT = 27
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pair_valid,
    output logic                 pair_ready,
    input  cdc_pair_t            pair,
    output logic                 verdict_valid,
    input  logic                 verdict_ready,
    output cdc_verdict_t         verdict,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    localparam int AW = (WORD_W + MAX_BLOCK_SHIFT > LOW_W + MIN_BLOCK_SHIFT) ?
                        (WORD_W + MAX_BLOCK_SHIFT + 1) : (LOW_W + MIN_BLOCK_SHIFT + 1);
    localparam int CW = (AW > NAPOT_W) ? AW : NAPOT_W;

    logic [CFG_W-1:0] perm_reg;
    logic [CFG_W-1:0] mode_reg;

    logic v1_reg;
    logic v2_reg;
    logic v3_reg;
    logic adv1;
    logic adv2;
    logic adv3;

    // stage 1 results
    logic [AW-1:0]      tag_sh;
    logic [AW-1:0]      pb_d_next;
    logic [AW-1:0]      pb_r_next;
    logic [AW-1:0]      pe_next;
    logic [LOW_W:0]     na;
    logic [LOW_W:0]     na1;
    logic [LOW_W+1:0]   nsz;
    logic [NAPOT_W-1:0] nb_next;
    logic [NAPOT_W-1:0] ne_next;

    logic [KIND_W-1:0]  pkind_reg;
    logic [KIND_W-1:0]  ckind_reg;
    logic [LOW_W-1:0]   plow_reg;
    logic [WORD_W-1:0]  pmark_reg;
    logic [WORD_W-1:0]  phigh_reg;
    logic [LOW_W-1:0]   clow_reg;
    logic [WORD_W-1:0]  chigh_reg;
    logic [AW-1:0]      pb_d_reg;
    logic [AW-1:0]      pb_r_reg;
    logic [AW-1:0]      pe_reg;
    logic [NAPOT_W-1:0] nb_reg;
    logic [NAPOT_W-1:0] ne_reg;
    logic key_eq_reg;
    logic low_eq_reg;
    logic rwx_sub_reg;
    logic rights_eq_reg;
    logic pkey_zero_reg;
    logic ckey_zero_reg;
    logic mark_eq_reg;
    logic pmp_ok_reg;
    logic sock_ok_reg;

    // stage 2 results
    cdc_flags_t       flags_next;
    cdc_flags_t       flags_reg;
    logic [LOW_W:0]   clow_inc;
    logic [LOW_W-1:0] pmark_w;
    logic [LOW_W-1:0] chigh_w;
    logic [LOW_W:0]   phigh_w;
    logic [CW-1:0]    nb_w;
    logic [CW-1:0]    ne_w;
    logic [CW-1:0]    pb_d_w;
    logic [CW-1:0]    pb_r_w;
    logic [CW-1:0]    pe_w;

    cdc_verdict_t verdict_next;
    cdc_verdict_t verdict_reg;

    assign adv3       = !v3_reg || verdict_ready;
    assign adv2       = !v2_reg || adv3;
    assign adv1       = !v1_reg || adv2;
    assign pair_ready = adv1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            perm_reg <= SOCKET_PERM_RESET;
            mode_reg <= SOCKET_MODE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SOCKET_PERM: perm_reg <= cfg_wdata;
                CFG_SOCKET_MODE: mode_reg <= cfg_wdata;
            endcase
        end
    end

    always_comb
    begin
        tag_sh    = {{(AW-WORD_W){1'b0}}, pair.parent_key} << MAX_BLOCK_SHIFT;
        pb_d_next = tag_sh + ({{(AW-WORD_W){1'b0}}, pair.parent_mark} << MIN_BLOCK_SHIFT);
        pb_r_next = tag_sh + ({{(AW-LOW_W){1'b0}}, pair.parent_low} << MIN_BLOCK_SHIFT);
        pe_next   = tag_sh + ({{(AW-WORD_W){1'b0}}, pair.parent_high} << MIN_BLOCK_SHIFT);
        na        = {1'b0, pair.child_low};
        na1       = na + {{LOW_W{1'b0}}, 1'b1};
        nsz       = {1'b0, na1 ^ na} + {{(LOW_W+1){1'b0}}, 1'b1};
        nb_next   = {1'b0, na1 & na, 2'b00};
        ne_next   = nb_next + {nsz, 2'b00};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                v1_reg <= pair_valid;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
            if (adv3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && pair_valid)
        begin
            pkind_reg     <= pair.parent_kind;
            ckind_reg     <= pair.child_kind;
            plow_reg      <= pair.parent_low;
            pmark_reg     <= pair.parent_mark;
            phigh_reg     <= pair.parent_high;
            clow_reg      <= pair.child_low;
            chigh_reg     <= pair.child_high;
            pb_d_reg      <= pb_d_next;
            pb_r_reg      <= pb_r_next;
            pe_reg        <= pe_next;
            nb_reg        <= nb_next;
            ne_reg        <= ne_next;
            key_eq_reg    <= pair.parent_key == pair.child_key;
            low_eq_reg    <= pair.parent_low == pair.child_low;
            rwx_sub_reg   <= (pair.child_rights[2:0] & ~pair.parent_rights[2:0]) == 3'd0;
            rights_eq_reg <= pair.parent_rights == pair.child_rights;
            pkey_zero_reg <= pair.parent_key == {WORD_W{1'b0}};
            ckey_zero_reg <= pair.child_key == {WORD_W{1'b0}};
            mark_eq_reg   <= pair.child_low == {{(LOW_W-WORD_W){1'b0}}, pair.child_mark};
            pmp_ok_reg    <= (pair.child_mark == {WORD_W{1'b0}}) &&
                             (pair.child_high == {WORD_W{1'b0}});
            sock_ok_reg   <= ((pair.child_rights[3:0] & ~perm_reg) == 4'd0) &&
                             ((pair.child_rights[7:4] & ~mode_reg) == 4'd0);
        end
    end

    always_comb
    begin
        clow_inc = {1'b0, clow_reg} + {{LOW_W{1'b0}}, 1'b1};
        pmark_w  = {{(LOW_W-WORD_W){1'b0}}, pmark_reg};
        chigh_w  = {{(LOW_W-WORD_W){1'b0}}, chigh_reg};
        phigh_w  = {{(LOW_W+1-WORD_W){1'b0}}, phigh_reg};
        nb_w     = {{(CW-NAPOT_W){1'b0}}, nb_reg};
        ne_w     = {{(CW-NAPOT_W){1'b0}}, ne_reg};
        pb_d_w   = CW'(pb_d_reg);
        pb_r_w   = CW'(pb_r_reg);
        pe_w     = CW'(pe_reg);

        flags_next.pkind         = pkind_reg;
        flags_next.ckind         = ckind_reg;
        flags_next.key_eq        = key_eq_reg;
        flags_next.low_eq        = low_eq_reg;
        flags_next.rwx_sub       = rwx_sub_reg;
        flags_next.rights_eq     = rights_eq_reg;
        flags_next.pkey_zero     = pkey_zero_reg;
        flags_next.ckey_zero     = ckey_zero_reg;
        flags_next.high_le       = chigh_reg <= phigh_reg;
        flags_next.mark_in       = (pmark_w <= clow_reg) && (chigh_reg <= phigh_reg);
        flags_next.low_in        = (plow_reg <= clow_reg) && (chigh_reg <= phigh_reg);
        flags_next.mark_sock_in  = (pmark_w <= clow_reg) && (clow_inc <= phigh_w);
        flags_next.low_sock_in   = (plow_reg <= clow_reg) && (clow_inc <= phigh_w);
        flags_next.pmp_derive_in = (pb_d_w <= nb_w) && (ne_w <= pe_w);
        flags_next.pmp_revoke_in = (pb_r_w <= nb_w) && (ne_w <= pe_w);
        flags_next.range_ok      = mark_eq_reg && (clow_reg < chigh_w);
        flags_next.pmp_ok        = pmp_ok_reg;
        flags_next.sock_ok       = sock_ok_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv2 && v1_reg)
        begin
            flags_reg <= flags_next;
        end
    end

    cdc_verdict u_verdict (
        .flags   (flags_reg),
        .verdict (verdict_next)
    );

    always_ff @(posedge clk)
    begin
        if (adv3 && v2_reg)
        begin
            verdict_reg <= verdict_next;
        end
    end

    assign verdict_valid = v3_reg;
    assign verdict       = verdict_reg;

endmodule
